// ===== sv/quaternion_to_yaw_defines.svh =====
// Assertion helpers for the quaternion-to-yaw block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef QUATERNION_TO_YAW_DEFINES_SVH
`define QUATERNION_TO_YAW_DEFINES_SVH

`ifndef SYNTHESIS

`define Q2Y_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("q2y check failed (same cycle)");

`define Q2Y_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("q2y check failed (next cycle)");

`else

`define Q2Y_ASSERT_SAME(label, ante, cons)

`define Q2Y_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/q2y_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package q2y_pkg;

  // Vector width: t3 needs 34 bits, t4 33 bits, plus CORDIC gain and headroom.
  localparam int VW       = 38;
  localparam int ANG_W    = 32;
  localparam int ATAN_LEN = 24;

  localparam logic signed [VW-1:0] ONE_Q28   = VW'(1) <<< 28;
  localparam logic [ANG_W-1:0]     HALF_TURN = 32'h8000_0000;
  localparam logic [ANG_W-1:0]     ROUND_BIT = 32'h0000_8000;

  // round(atan(2^-i) * 2^32 / (2*pi))
  localparam logic [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic [ANG_W-1:0]     acc;
    logic                 zero;
  } cordic_t;

endpackage

`default_nettype wire

// ===== sv/q2y_ifaces.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface q2y_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2y_yaw_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_angle;

  modport source (output valid, yaw_angle, input ready);
  modport sink   (input valid, yaw_angle, output ready);
endinterface

`default_nettype wire

// ===== sv/q2y_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Products, then t3/t4, then half-plane fold and accumulator preload.
module q2y_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  q2y_quat_if.sink         quat,
  output q2y_pkg::cordic_t dat_o,
  output logic             vld_o,
  input  wire logic        rdy_i
);

  logic v0_r, v1_r, v2_r;
  logic rdy0, rdy1, rdy2;

  logic signed [31:0] p_wz_r, p_xy_r, p_yy_r, p_zz_r;
  logic signed [q2y_pkg::VW-1:0] t3_r, t4_r, t3_nxt, t4_nxt;
  q2y_pkg::cordic_t dat_r, dat_nxt;

  assign rdy2 = !v2_r || rdy_i;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;
  assign quat.ready = rdy0;

  always_comb begin
    t3_nxt = (q2y_pkg::VW'(p_wz_r) + q2y_pkg::VW'(p_xy_r)) <<< 1;
    t4_nxt = q2y_pkg::ONE_Q28 - ((q2y_pkg::VW'(p_yy_r) + q2y_pkg::VW'(p_zz_r)) <<< 1);
  end

  always_comb begin
    dat_nxt.zero = (t3_r == '0) && (t4_r == '0);
    if (t4_r[q2y_pkg::VW-1]) begin
      // left half plane: rotate by pi first
      dat_nxt.vx  = -t4_r;
      dat_nxt.vy  = -t3_r;
      dat_nxt.acc = q2y_pkg::HALF_TURN;
    end else begin
      dat_nxt.vx  = t4_r;
      dat_nxt.vy  = t3_r;
      dat_nxt.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= quat.valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && quat.valid) begin
      p_wz_r <= quat.quat_w * quat.quat_z;
      p_xy_r <= quat.quat_x * quat.quat_y;
      p_yy_r <= quat.quat_y * quat.quat_y;
      p_zz_r <= quat.quat_z * quat.quat_z;
    end
    if (rdy1 && v0_r) begin
      t3_r <= t3_nxt;
      t4_r <= t4_nxt;
    end
    if (rdy2 && v1_r) begin
      dat_r <= dat_nxt;
    end
  end

  assign dat_o = dat_r;
  assign vld_o = v2_r;

endmodule

`default_nettype wire

// ===== sv/q2y_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One CORDIC vectoring micro-rotation, registered.
module q2y_cell #(
  parameter int STAGE = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire q2y_pkg::cordic_t dat_i,
  input  wire logic             vld_i,
  output logic                  rdy_o,
  output q2y_pkg::cordic_t      dat_o,
  output logic                  vld_o,
  input  wire logic             rdy_i
);

  logic             vld_r;
  q2y_pkg::cordic_t dat_r, dat_nxt;
  logic signed [q2y_pkg::VW-1:0] dx, dy;

  assign rdy_o = !vld_r || rdy_i;

  always_comb begin
    dx = dat_i.vy >>> STAGE;
    dy = dat_i.vx >>> STAGE;
    dat_nxt.zero = dat_i.zero;
    if (!dat_i.vy[q2y_pkg::VW-1]) begin
      dat_nxt.vx  = dat_i.vx + dx;
      dat_nxt.vy  = dat_i.vy - dy;
      dat_nxt.acc = dat_i.acc + q2y_pkg::ATAN_TAB[STAGE];
    end else begin
      dat_nxt.vx  = dat_i.vx - dx;
      dat_nxt.vy  = dat_i.vy + dy;
      dat_nxt.acc = dat_i.acc - q2y_pkg::ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      dat_r <= dat_nxt;
    end
  end

  assign dat_o = dat_r;
  assign vld_o = vld_r;

endmodule

`default_nettype wire

// ===== sv/quaternion_to_yaw.sv =====
// Channel   Dir  Payload                             Handshake
// in_quat   in   quat_w, quat_x, quat_y, quat_z      valid/ready
// out_yaw   out  yaw_angle                           valid/ready
//
// The pipeline has three front stages (multiply, combine, fold), one cell per
// micro-rotation (CORDIC_STAGES, capped at 24) and one output register.
// One quaternion is taken every cycle while the result side keeps up.
// Every stage stalls on its own, so bubbles close up behind a stalled output.
// Reset is synchronous and clears only the stage valid bits.
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_to_yaw_defines.svh"

module quaternion_to_yaw #(
  parameter int CORDIC_STAGES = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  q2y_quat_if.sink  in_quat,
  q2y_yaw_if.source out_yaw
);

  localparam int NSTG = (CORDIC_STAGES > q2y_pkg::ATAN_LEN) ? q2y_pkg::ATAN_LEN
                                                             : CORDIC_STAGES;

  logic             vld [NSTG+1];
  logic             rdy [NSTG+1];
  q2y_pkg::cordic_t dat [NSTG+1];

  logic               out_vld_r;
  logic signed [15:0] yaw_r;
  logic [q2y_pkg::ANG_W-1:0] acc_rnd;

  q2y_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .quat  (in_quat),
    .dat_o (dat[0]),
    .vld_o (vld[0]),
    .rdy_i (rdy[0])
  );

  for (genvar k = 0; k < NSTG; k++) begin : g_cell
    q2y_cell #(.STAGE(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .dat_i (dat[k]),
      .vld_i (vld[k]),
      .rdy_o (rdy[k]),
      .dat_o (dat[k+1]),
      .vld_o (vld[k+1]),
      .rdy_i (rdy[k+1])
    );
  end

  assign rdy[NSTG] = !out_vld_r || out_yaw.ready;
  assign acc_rnd   = dat[NSTG].acc + q2y_pkg::ROUND_BIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rdy[NSTG]) begin
      out_vld_r <= vld[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG] && vld[NSTG]) begin
      // zero vector: atan2(0, 0) is 0
      yaw_r <= dat[NSTG].zero ? '0 : acc_rnd[q2y_pkg::ANG_W-1 -: 16];
    end
  end

  assign out_yaw.valid     = out_vld_r;
  assign out_yaw.yaw_angle = yaw_r;

  `Q2Y_ASSERT_SAME(a_fold_right_half, vld[0], !dat[0].vx[q2y_pkg::VW-1])
  `Q2Y_ASSERT_SAME(a_zero_vector, vld[0] && dat[0].zero, (dat[0].vx == '0) && (dat[0].vy == '0))
  `Q2Y_ASSERT_NEXT(a_last_handoff, vld[NSTG] && rdy[NSTG], out_vld_r)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int RANDOM_QUATS  = 1850;
  localparam int HOLD_AT_COUNT = 700;
  localparam int HOLD_CYCLES   = 400;

  // receiver stall patterns
  localparam int RX_ALWAYS   = 0;
  localparam int RX_MOSTLY   = 1;
  localparam int RX_SELDOM   = 2;
  localparam int RX_PERIODIC = 3;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    bit                 typed;
    logic signed [15:0] yaw;
  } quat_row_t;

  // binary-angle arctangent steps, 2^32 per full turn
  localparam logic [31:0] ARCTAN_STEP [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  localparam int DIRECTED_ROWS = 22;

  // w, x, y, z, typed, yaw
  quat_row_t directed [DIRECTED_ROWS] = '{
    '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0},
    '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0},
    '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b1, 16'sd0},
    // half turn about z: heading at pi wraps to the most negative code
    '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b1, 16'h8000},
    '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b1, 16'h8000},
    // both atan2 arguments zero
    '{16'sd0, 16'sd0, 16'sd8192, 16'sd8192, 1'b1, 16'sd0},
    '{16'sd5000, -16'sd5000, 16'sd8192, 16'sd8192, 1'b1, 16'sd0},
    '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 1'b0, 16'sd0},
    '{16'sd11585, 16'sd0, 16'sd0, -16'sd11585, 1'b0, 16'sd0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 16'sd0},
    '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 16'sd0},
    '{16'sd32767, 16'h8000, 16'sd32767, 16'h8000, 1'b0, 16'sd0},
    '{16'h8000, 16'sd32767, 16'h8000, 16'sd32767, 1'b0, 16'sd0},
    '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b0, 16'sd0},
    '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 1'b0, 16'sd0},
    '{16'sd1, 16'sd0, 16'sd0, -16'sd1, 1'b0, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd1, 16'sd0, 1'b0, 16'sd0},
    '{16'sd0, -16'sd16384, 16'sd16384, 16'sd0, 1'b0, 16'sd0},
    // just either side of pi in the left half plane
    '{16'sd1, 16'sd0, 16'sd0, 16'sd16384, 1'b0, 16'sd0},
    '{-16'sd1, 16'sd0, 16'sd0, 16'sd16384, 1'b0, 16'sd0},
    '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0}
  };

  logic clk;
  logic rst_n = 1'b0;

  q2y_quat_if quat_ch ();
  q2y_yaw_if  yaw_ch ();

  quaternion_to_yaw #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_quat(quat_ch.sink),
    .out_yaw(yaw_ch.source)
  );

  logic signed [15:0] yaw_expected [$];
  int                 mismatch_count = 0;
  int                 quats_taken    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[quaternion_to_yaw] ERROR");
    $finish;
  end

  function automatic logic signed [15:0] heading_of(logic signed [15:0] w, logic signed [15:0] x,
                                                    logic signed [15:0] y, logic signed [15:0] z);
    longint      qw, qx, qy, qz;
    longint      vx, vy, dx, dy;
    logic [31:0] angle;
    int          stages;
    qw = w;
    qx = x;
    qy = y;
    qz = z;
    vy = 2 * (qw * qz + qx * qy);
    vx = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
    if (vx == 0 && vy == 0) return 16'sd0;
    angle  = 32'd0;
    stages = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    // fold the left half plane over, starting from a half turn
    if (vx < 0) begin
      vx    = -vx;
      vy    = -vy;
      angle = 32'h8000_0000;
    end
    for (int i = 0; i < stages; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx    = vx + dx;
        vy    = vy - dy;
        angle = angle + ARCTAN_STEP[i];
      end else begin
        vx    = vx - dx;
        vy    = vy + dy;
        angle = angle - ARCTAN_STEP[i];
      end
    end
    angle = angle + 32'h0000_8000;
    return angle[31:16];
  endfunction

  function automatic logic signed [15:0] in_range();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic quat_row_t random_quat();
    quat_row_t r;
    real       cw, cx, cy, cz, mag;
    int        kind;
    r    = '0;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        r.w = 16'($urandom());
        r.x = 16'($urandom());
        r.y = 16'($urandom());
        r.z = 16'($urandom());
      end
      2, 3, 4, 5, 7: begin
        cw = $itor($signed($urandom_range(0, 65535)) - 32768);
        cx = $itor($signed($urandom_range(0, 65535)) - 32768);
        cy = $itor($signed($urandom_range(0, 65535)) - 32768);
        cz = $itor($signed($urandom_range(0, 65535)) - 32768);
        // pure yaw rotations: x and y are zero before the small noise is added
        if (kind == 7) begin
          cx = 0.0;
          cy = 0.0;
        end
        mag = $sqrt(cw * cw + cx * cx + cy * cy + cz * cz);
        if (mag < 1.0) begin
          cw  = 1.0;
          mag = 1.0;
        end
        r.w = 16'($rtoi(16384.0 * cw / mag) + $signed($urandom_range(0, 8)) - 4);
        r.x = 16'($rtoi(16384.0 * cx / mag) + $signed($urandom_range(0, 8)) - 4);
        r.y = 16'($rtoi(16384.0 * cy / mag) + $signed($urandom_range(0, 8)) - 4);
        r.z = 16'($rtoi(16384.0 * cz / mag) + $signed($urandom_range(0, 8)) - 4);
      end
      6: begin
        r.w = in_range();
        r.x = in_range();
        r.y = in_range();
        r.z = in_range();
      end
      8: begin
        // y^2 + z^2 = 2^27 puts t4 at zero; x = -w also zeroes t3
        r.y = $urandom_range(0, 1) ? 16'sd8192 : -16'sd8192;
        r.z = r.y;
        r.w = in_range();
        r.x = $urandom_range(0, 1) ? -r.w : in_range();
      end
      default: begin
        r.w = 16'($signed($urandom_range(0, 15)) - 8);
        r.x = 16'($signed($urandom_range(0, 15)) - 8);
        r.y = 16'($signed($urandom_range(0, 15)) - 8);
        r.z = 16'($signed($urandom_range(0, 15)) - 8);
      end
    endcase
    return r;
  endfunction

  // call at a falling edge; returns at the falling edge after the request is taken
  task automatic offer_quat(quat_row_t r);
    quat_ch.valid  <= 1'b1;
    quat_ch.quat_w <= r.w;
    quat_ch.quat_x <= r.x;
    quat_ch.quat_y <= r.y;
    quat_ch.quat_z <= r.z;
    do @(posedge clk); while (!quat_ch.ready);
    yaw_expected.push_back(r.typed ? r.yaw : heading_of(r.w, r.x, r.y, r.z));
    quats_taken++;
    @(negedge clk);
  endtask

  task automatic maybe_pause();
    int gap;
    if ($urandom_range(0, 3) != 0) begin
      gap = $urandom_range(1, 8);
      quat_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    int burst;
    int sent;
    quat_ch.valid  = 1'b0;
    quat_ch.quat_w = '0;
    quat_ch.quat_x = '0;
    quat_ch.quat_y = '0;
    quat_ch.quat_z = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_quat(directed[i]);
      if ($urandom_range(0, 2) == 0) maybe_pause();
    end

    sent = 0;
    while (sent < RANDOM_QUATS) begin
      burst = $urandom_range(1, 48);
      for (int k = 0; k < burst && sent < RANDOM_QUATS; k++) begin
        offer_quat(random_quat());
        sent++;
      end
      maybe_pause();
    end
    quat_ch.valid <= 1'b0;

    while (yaw_expected.size() != 0) @(posedge clk);
    repeat (CORDIC_STAGES + 12) @(posedge clk);
    if (mismatch_count == 0 && yaw_expected.size() == 0) begin
      $display("[quaternion_to_yaw] OK");
    end else begin
      $display("[quaternion_to_yaw] ERROR");
    end
    $finish;
  end

  // result side: random stall patterns, plus one long hold-off to back up the pipe
  initial begin
    int  mode;
    int  cyc;
    bit  held;
    yaw_ch.ready = 1'b0;
    held         = 1'b0;
    cyc          = 0;
    forever begin
      mode = $urandom_range(RX_ALWAYS, RX_PERIODIC);
      repeat ($urandom_range(16, 96)) begin
        @(negedge clk);
        cyc++;
        if (!held && quats_taken >= HOLD_AT_COUNT) begin
          held = 1'b1;
          yaw_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
        end else begin
          case (mode)
            RX_ALWAYS:   yaw_ch.ready <= 1'b1;
            RX_MOSTLY:   yaw_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_SELDOM:   yaw_ch.ready <= ($urandom_range(0, 3) == 0);
            default:     yaw_ch.ready <= ((cyc % 5) < 2);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst_n && yaw_ch.valid && yaw_ch.ready) begin
      if (yaw_expected.size() == 0) begin
        $error("yaw_angle: no result expected, got %0d", yaw_ch.yaw_angle);
        mismatch_count++;
      end else begin
        want = yaw_expected.pop_front();
        if (yaw_ch.yaw_angle !== want) begin
          $error("yaw_angle: expected %0d, actual %0d", want, yaw_ch.yaw_angle);
          mismatch_count++;
        end
      end
    end
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/q2y_pkg.sv
sv/q2y_ifaces.sv
sv/q2y_front.sv
sv/q2y_cell.sv
sv/quaternion_to_yaw.sv
tb/testbench.sv
